// ===== rtl/core/tcgr_pkg.sv =====
// Shared constants, register indexes and controller/datapath structs for the
// text cursor glyph rasteriser. No dependencies.
package tcgr_pkg;

    localparam int ROW_PIXELS   = 64;
    localparam int HEIGHT_LIMIT = 100;
    localparam int WIDE_LIMIT   = 100;

    localparam int OP_W       = 2;
    localparam int COORD_W    = 16;
    localparam int COLOR_W    = 8;
    localparam int HEIGHT_W   = 8;
    localparam int TAB_W      = 9;
    localparam int GW_W       = 7;
    localparam int COUNT_W    = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int REM_W      = TAB_W + 1;
    localparam int DIV_STEPS  = COORD_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic [OP_W-1:0] OP_NEWLINE = 2'd0;
    localparam logic [OP_W-1:0] OP_TAB     = 2'd1;
    localparam logic [OP_W-1:0] OP_GLYPH   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR       = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BG_TRANSPARENT = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_BASELINE = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TAB_WIDTH      = 4'd7;

    localparam logic [COLOR_W-1:0]  RST_FG_COLOR  = 8'd15;
    localparam logic [COLOR_W-1:0]  RST_BG_COLOR  = 8'd0;
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT    = 8'd8;
    localparam logic [HEIGHT_W-1:0] RST_BASELINE  = 8'd7;
    localparam logic [TAB_W-1:0]    RST_TAB_WIDTH = 9'd16;

    typedef struct packed {
        logic newline;
        logic tab_start;
        logic div_step;
        logic tab_apply;
        logic row_load;
        logic scan_step;
        logic row_finish;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic scan_empty;
        logic cur_emit;
        logic out_free;
    } stat_t;

endpackage

// ===== rtl/core/tcgr_item_if.sv =====
// Input item channel: newline, tab or glyph row beats.
// Depends on tcgr_pkg.
interface tcgr_item_if;
    import tcgr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [OP_W-1:0]       operation;
    logic [ROW_PIXELS-1:0] row_bits;
    logic [GW_W-1:0]       glyph_width;
    logic                  last_row;

    modport source (output valid, operation, row_bits, glyph_width, last_row, input ready);
    modport sink (input valid, operation, row_bits, glyph_width, last_row, output ready);
endinterface

// ===== rtl/core/tcgr_pixel_if.sv =====
// Result channel: one pixel write per beat.
// Depends on tcgr_pkg.
interface tcgr_pixel_if;
    import tcgr_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] pixel_x;
    logic signed [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0]        pixel_color;
    logic                      row_done;
    logic [COUNT_W-1:0]        chars_drawn;

    modport source (output valid, pixel_x, pixel_y, pixel_color, row_done, chars_drawn,
                    input ready);
    modport sink (input valid, pixel_x, pixel_y, pixel_color, row_done, chars_drawn,
                  output ready);
endinterface

// ===== rtl/core/tcgr_cfg_if.sv =====
// Configuration write channel: register index and write data per beat.
// Depends on tcgr_pkg.
interface tcgr_cfg_if;
    import tcgr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/tcgr_dp.sv =====
// Datapath: configuration registers, text cursor, tab remainder divider,
// glyph row scanner and pixel output register. Depends on tcgr_pkg and interfaces.
module tcgr_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tcgr_pkg::cmd_t                    cmd,
    output tcgr_pkg::stat_t                   stat,
    input  logic [tcgr_pkg::ROW_PIXELS-1:0]   row_bits,
    input  logic [tcgr_pkg::GW_W-1:0]         glyph_width,
    input  logic                              last_row,
    tcgr_cfg_if.sink                          cfg,
    tcgr_pixel_if.source                      pixel
);
    import tcgr_pkg::*;

    logic [COORD_W-1:0]    origin_x_reg, origin_y_reg;
    logic [COLOR_W-1:0]    fg_color_reg, bg_color_reg;
    logic                  bg_transparent_reg;
    logic [HEIGHT_W-1:0]   height_reg, baseline_reg;
    logic [TAB_W-1:0]      tab_width_reg;

    logic [COORD_W-1:0]    cursor_x_reg, cursor_x_next;
    logic [COORD_W-1:0]    cursor_y_reg, cursor_y_next;
    logic [HEIGHT_W-1:0]   row_index_reg, row_index_next;
    logic [COUNT_W-1:0]    drawn_count_reg, drawn_count_next;

    logic                  tab_neg_reg;
    logic [COORD_W-1:0]    div_a_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [DIV_CNT_W-1:0]  div_cnt_reg;
    logic [REM_W-1:0]      rem_sh;
    logic [REM_W-1:0]      tab_rem;

    logic [ROW_PIXELS-1:0] bits_sr_reg, emit_sr_reg;
    logic [GW_W-1:0]       width_reg;
    logic                  last_reg;
    logic [COORD_W-1:0]    px_reg, py_reg;
    logic [GW_W-1:0]       cols;
    logic [ROW_PIXELS-1:0] col_mask;
    logic                  draw_en;
    logic                  cfg_wr;
    logic                  out_load;

    logic                  out_valid_reg;
    logic [COORD_W-1:0]    out_x_reg, out_y_reg;
    logic [COLOR_W-1:0]    out_color_reg;
    logic                  out_done_reg;
    logic [COUNT_W-1:0]    out_chars_reg;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg       <= '0;
            origin_y_reg       <= '0;
            fg_color_reg       <= RST_FG_COLOR;
            bg_color_reg       <= RST_BG_COLOR;
            bg_transparent_reg <= 1'b1;
            height_reg         <= RST_HEIGHT;
            baseline_reg       <= RST_BASELINE;
            tab_width_reg      <= RST_TAB_WIDTH;
        end
        else if (cfg_wr)
        begin
            case (cfg.index)
                REG_ORIGIN_X:       origin_x_reg       <= cfg.data[COORD_W-1:0];
                REG_ORIGIN_Y:       origin_y_reg       <= cfg.data[COORD_W-1:0];
                REG_FG_COLOR:       fg_color_reg       <= cfg.data[COLOR_W-1:0];
                REG_BG_COLOR:       bg_color_reg       <= cfg.data[COLOR_W-1:0];
                REG_BG_TRANSPARENT: bg_transparent_reg <= cfg.data[0];
                REG_GLYPH_HEIGHT:   height_reg         <= cfg.data[HEIGHT_W-1:0];
                REG_GLYPH_BASELINE: baseline_reg       <= cfg.data[HEIGHT_W-1:0];
                REG_TAB_WIDTH:      tab_width_reg      <= cfg.data[TAB_W-1:0];
                default:            ;
            endcase
        end
    end

    assign rem_sh  = {rem_reg[REM_W-2:0], div_a_reg[COORD_W-1]};
    assign tab_rem = (tab_neg_reg && (rem_reg != '0)) ?
                     (REM_W'(tab_width_reg) - rem_reg) : rem_reg;

    always_comb
    begin
        cursor_x_next    = cursor_x_reg;
        cursor_y_next    = cursor_y_reg;
        row_index_next   = row_index_reg;
        drawn_count_next = drawn_count_reg;
        if (cfg_wr && (cfg.index == REG_ORIGIN_X))
            cursor_x_next = cfg.data[COORD_W-1:0];
        if (cfg_wr && (cfg.index == REG_ORIGIN_Y))
            cursor_y_next = cfg.data[COORD_W-1:0];
        if (cmd.newline)
        begin
            cursor_x_next = origin_x_reg;
            cursor_y_next = cursor_y_reg + COORD_W'(height_reg) + COORD_W'(2);
        end
        if (cmd.tab_apply && (tab_width_reg != '0))
            cursor_x_next = cursor_x_reg + COORD_W'(tab_width_reg) - COORD_W'(tab_rem);
        if (cmd.row_finish)
        begin
            if (last_reg)
            begin
                cursor_x_next  = cursor_x_reg + COORD_W'(width_reg);
                row_index_next = '0;
                if (drawn_count_reg != {COUNT_W{1'b1}})
                    drawn_count_next = drawn_count_reg + COUNT_W'(1);
            end
            else if (row_index_reg != {HEIGHT_W{1'b1}})
                row_index_next = row_index_reg + HEIGHT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg    <= '0;
            cursor_y_reg    <= '0;
            row_index_reg   <= '0;
            drawn_count_reg <= '0;
            div_cnt_reg     <= '0;
        end
        else
        begin
            cursor_x_reg    <= cursor_x_next;
            cursor_y_reg    <= cursor_y_next;
            row_index_reg   <= row_index_next;
            drawn_count_reg <= drawn_count_next;
            if (cmd.tab_start)
                div_cnt_reg <= '0;
            else if (cmd.div_step)
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
    end

    // Remainder of |x| by tab width, one bit per step
    always_ff @(posedge clk)
    begin
        if (cmd.tab_start)
        begin
            tab_neg_reg <= cursor_x_reg[COORD_W-1];
            div_a_reg   <= cursor_x_reg[COORD_W-1] ? (-cursor_x_reg) : cursor_x_reg;
            rem_reg     <= '0;
        end
        else if (cmd.div_step)
        begin
            div_a_reg <= {div_a_reg[COORD_W-2:0], 1'b0};
            rem_reg   <= (rem_sh >= REM_W'(tab_width_reg)) ?
                         (rem_sh - REM_W'(tab_width_reg)) : rem_sh;
        end
    end

    assign draw_en  = (height_reg <= HEIGHT_W'(HEIGHT_LIMIT)) &&
                      (glyph_width <= GW_W'(WIDE_LIMIT)) &&
                      (row_index_reg < height_reg);
    assign cols     = (glyph_width > GW_W'(ROW_PIXELS)) ? GW_W'(ROW_PIXELS) : glyph_width;
    assign col_mask = ~({ROW_PIXELS{1'b1}} >> cols);

    always_ff @(posedge clk)
    begin
        if (cmd.row_load)
        begin
            bits_sr_reg <= row_bits;
            emit_sr_reg <= draw_en ?
                           ((row_bits | {ROW_PIXELS{~bg_transparent_reg}}) & col_mask) : '0;
            width_reg   <= glyph_width;
            last_reg    <= last_row;
            px_reg      <= cursor_x_reg;
            py_reg      <= cursor_y_reg - COORD_W'(height_reg) + COORD_W'(baseline_reg) +
                           COORD_W'(row_index_reg);
        end
        else if (cmd.scan_step)
        begin
            bits_sr_reg <= {bits_sr_reg[ROW_PIXELS-2:0], 1'b0};
            emit_sr_reg <= {emit_sr_reg[ROW_PIXELS-2:0], 1'b0};
            px_reg      <= px_reg + COORD_W'(1);
        end
    end

    assign out_load = cmd.scan_step && emit_sr_reg[ROW_PIXELS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (pixel.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_x_reg     <= px_reg;
            out_y_reg     <= py_reg;
            out_color_reg <= bits_sr_reg[ROW_PIXELS-1] ? fg_color_reg : bg_color_reg;
            out_done_reg  <= (emit_sr_reg[ROW_PIXELS-2:0] == '0);
            out_chars_reg <= drawn_count_reg;
        end
    end

    assign pixel.valid       = out_valid_reg;
    assign pixel.pixel_x     = out_x_reg;
    assign pixel.pixel_y     = out_y_reg;
    assign pixel.pixel_color = out_color_reg;
    assign pixel.row_done    = out_done_reg;
    assign pixel.chars_drawn = out_chars_reg;

    assign stat.div_done   = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS));
    assign stat.scan_empty = (emit_sr_reg == '0);
    assign stat.cur_emit   = emit_sr_reg[ROW_PIXELS-1];
    assign stat.out_free   = !out_valid_reg || pixel.ready;

    a_div_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        div_cnt_reg <= DIV_CNT_W'(DIV_STEPS))
        else $error("divider step count overran");

    a_last_clears_row: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.row_finish && last_reg) |=> (row_index_reg == '0))
        else $error("last row did not clear row index");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || pixel.ready))
        else $error("pixel beat overwritten before it was taken");

endmodule

// ===== rtl/core/tcgr_ctrl.sv =====
// Controller: sequences newline, tab division and glyph row scanning.
// Depends on tcgr_pkg.
module tcgr_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    input  logic [tcgr_pkg::OP_W-1:0]   operation,
    output logic                        item_ready,
    output tcgr_pkg::cmd_t              cmd,
    input  tcgr_pkg::stat_t             stat
);
    import tcgr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_TAB  = 2'd2;
    localparam logic [1:0] S_SCAN = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       accept;

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (operation)
                        OP_NEWLINE: cmd.newline = 1'b1;
                        OP_TAB:
                        begin
                            cmd.tab_start = 1'b1;
                            state_next    = S_DIV;
                        end
                        OP_GLYPH:
                        begin
                            cmd.row_load = 1'b1;
                            state_next   = S_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                    state_next = S_TAB;
                else
                    cmd.div_step = 1'b1;
            end
            S_TAB:
            begin
                cmd.tab_apply = 1'b1;
                state_next    = S_IDLE;
            end
            S_SCAN:
            begin
                if (stat.scan_empty)
                begin
                    cmd.row_finish = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (!stat.cur_emit || stat.out_free)
                    cmd.scan_step = 1'b1;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_div_to_tab: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DIV) && stat.div_done) |=> (state_reg == S_TAB))
        else $error("divider finish did not lead to tab update");

endmodule

// ===== rtl/core/text_cursor_glyph_rasterizer_unit.sv =====
// Top level of the text cursor glyph rasteriser: controller plus datapath.
// Depends on tcgr_pkg, tcgr_item_if, tcgr_pixel_if, tcgr_cfg_if, tcgr_ctrl, tcgr_dp.
//
//   channel  role   beat contents
//   item     sink   operation, row_bits, glyph_width, last_row
//   pixel    source pixel_x, pixel_y, pixel_color, row_done, chars_drawn
//   cfg      sink   index, data (always ready)
//
// Newline: cursor moved as the item is taken. Tab: 16 remainder steps in the divider,
// then the cursor update. Glyph row: columns scanned one per cycle up to the last
// drawn one, stalled while a pixel beat waits on a full output register.
// Reset is asynchronous, active low; no clearing pass.
// Items are taken only with the controller idle; the output register holds a
// pixel beat while the next item is accepted.
module text_cursor_glyph_rasterizer_unit (
    input logic          clk,
    input logic          rst_n,
    tcgr_item_if.sink    item,
    tcgr_pixel_if.source pixel,
    tcgr_cfg_if.sink     cfg
);
    import tcgr_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  item_ready;

    assign item.ready = item_ready;

    tcgr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .operation  (item.operation),
        .item_ready (item_ready),
        .cmd        (cmd),
        .stat       (stat)
    );

    tcgr_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .row_bits    (item.row_bits),
        .glyph_width (item.glyph_width),
        .last_row    (item.last_row),
        .cfg         (cfg),
        .pixel       (pixel)
    );

endmodule
